@@ hw/rtl/jkam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_pkg
// Shared types and constants for the kanji ROM address map unit.
// ----------------------------------------------------------------------------
package jkam_pkg;

    localparam int unsigned CODE_W  = 16;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned SRC_W   = 19;
    localparam int unsigned LEFT_W  = 17;
    localparam int unsigned RIGHT_W = 18;
    localparam int unsigned BANK_W  = 5;

    localparam int unsigned ROWS_PER_GLYPH = 16;
    localparam logic [ROW_W-1:0]   ROW_LAST = ROW_W'(ROWS_PER_GLYPH - 1);
    localparam logic [RIGHT_W-1:0] RIGHT_HALF_OFFSET = 18'd131072;

    // Shift-JIS windows of the packed source font
    localparam logic [15:0] SJ_A_LO = 16'h8140;
    localparam logic [15:0] SJ_A_HI = 16'h84c0;
    localparam logic [15:0] SJ_B_LO = 16'h8890;
    localparam logic [15:0] SJ_B_HI = 16'ha000;
    localparam logic [15:0] SJ_C_LO = 16'he040;
    localparam logic [15:0] SJ_C_HI = 16'heab0;
    localparam logic [SRC_W-1:0] SRC_BASE_A = 19'h00000;
    localparam logic [SRC_W-1:0] SRC_BASE_B = 19'h07000;
    localparam logic [SRC_W-1:0] SRC_BASE_C = 19'h35e00;

    localparam logic [7:0] BANK_TABLE [64] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'h00, 8'h02, 8'h01, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'h04, 8'h06, 8'h08, 8'hff, 8'h05, 8'h07, 8'h09,
        8'hff, 8'h0a, 8'h0c, 8'h0e, 8'hff, 8'h0b, 8'h0d, 8'h0f,
        8'hff, 8'h10, 8'h12, 8'h14, 8'hff, 8'h11, 8'h13, 8'h15,
        8'hff, 8'h16, 8'h18, 8'h1a, 8'hff, 8'h17, 8'h19, 8'h1b,
        8'hff, 8'h1c, 8'h1e, 8'h1d, 8'hff, 8'hff, 8'hff, 8'hff
    };

    // decode -> offset stage
    typedef struct packed {
        logic              ok;
        logic [15:0]       sj;
        logic [BANK_W-1:0] bank;
        logic [2:0]        cell_hi;   // code[10:8]
        logic [4:0]        cell_lo;   // code[4:0]
    } dec_beat_t;

    // offset -> row generator
    typedef struct packed {
        logic              ok;
        logic [SRC_W-1:0]  src;
        logic [LEFT_W-1:0] dst;
    } base_beat_t;

endpackage

@@ hw/rtl/jkam_code_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_code_if
// Input channel: one JIS code per beat.
// ----------------------------------------------------------------------------
interface jkam_code_if import jkam_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] jis_code;

    modport source (output valid, output jis_code, input ready);
    modport sink   (input valid, input jis_code, output ready);
endinterface

@@ hw/rtl/jkam_row_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_row_if
// Output channel: one glyph row copy descriptor per beat.
// ----------------------------------------------------------------------------
interface jkam_row_if import jkam_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               copy_valid;
    logic [ROW_W-1:0]   row_index;
    logic [SRC_W-1:0]   source_offset;
    logic [LEFT_W-1:0]  dest_left_offset;
    logic [RIGHT_W-1:0] dest_right_offset;
    logic               last_row;

    modport source (output valid, output copy_valid, output row_index,
                    output source_offset, output dest_left_offset,
                    output dest_right_offset, output last_row, input ready);
    modport sink   (input valid, input copy_valid, input row_index,
                    input source_offset, input dest_left_offset,
                    input dest_right_offset, input last_row, output ready);
endinterface

@@ hw/rtl/jis_kanji_rom_address_map_unit.sv @@
`timescale 1ns / 1ps
// The first result beat of a code leaves the row generator register, after the decode and offset stage registers.
// One result beat per cycle while the sink holds ready; a mapped code gives 16 beats, an unmapped code one.
// The row generator sets that figure; the two stages ahead of it hold one code each meanwhile.
// Reset (rst_n, async, active low) clears all stage valid bits; no state survives an item.
// ----------------------------------------------------------------------------
// jis_kanji_rom_address_map_unit
// Maps JIS kanji codes to source font and split kanji ROM row offsets.
// ----------------------------------------------------------------------------
module jis_kanji_rom_address_map_unit import jkam_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    jkam_code_if.sink  code_ch,
    jkam_row_if.source row_ch
);

    logic       dec_valid;
    logic       dec_ready;
    dec_beat_t  dec_beat;
    logic       base_valid;
    logic       base_ready;
    base_beat_t base_beat;

    jkam_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (code_ch.valid),
        .in_ready (code_ch.ready),
        .jis_code (code_ch.jis_code),
        .dn_valid (dec_valid),
        .dn_ready (dec_ready),
        .dn_beat  (dec_beat)
    );

    jkam_offset u_offset (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dec_valid),
        .up_ready (dec_ready),
        .up_beat  (dec_beat),
        .dn_valid (base_valid),
        .dn_ready (base_ready),
        .dn_beat  (base_beat)
    );

    jkam_row_gen u_row_gen (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (base_valid),
        .up_ready (base_ready),
        .up_beat  (base_beat),
        .row_ch   (row_ch)
    );

endmodule

@@ hw/rtl/jkam_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_decode
// Stage 1: range check, JIS to Shift-JIS conversion and bank table lookup.
// ----------------------------------------------------------------------------
module jkam_decode import jkam_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CODE_W-1:0] jis_code,
    output logic              dn_valid,
    input  logic              dn_ready,
    output dec_beat_t         dn_beat
);

    logic       valid_reg;
    dec_beat_t  beat_reg;
    dec_beat_t  beat_next;

    logic [7:0] row;
    logic [7:0] jcell;
    logic       range_ok;
    logic [8:0] row_p1;
    logic [7:0] lead;
    logic [7:0] trail;
    logic [5:0] bank_idx;
    logic [7:0] bank_entry;

    always_comb
    begin
        row      = jis_code[15:8];
        jcell    = jis_code[7:0];
        range_ok = (row >= 8'h21) && (row <= 8'h7e) && (jcell >= 8'h21) && (jcell <= 8'h7e);
        row_p1   = {1'b0, row} + 9'd1;
        lead     = row_p1[8:1] + ((row <= 8'h5e) ? 8'h70 : 8'hb0);
        if (row[0])
        begin
            trail = jcell + ((jcell >= 8'h60) ? 8'h20 : 8'h1f);
        end
        else
        begin
            trail = jcell + 8'h7e;
        end
        bank_idx   = {jis_code[14:11], jis_code[6:5]};
        bank_entry = BANK_TABLE[bank_idx];

        beat_next.ok      = range_ok && (bank_entry[7:6] == 2'b00);
        beat_next.sj      = {lead, trail};
        beat_next.bank    = bank_entry[BANK_W-1:0];
        beat_next.cell_hi = jis_code[10:8];
        beat_next.cell_lo = jis_code[4:0];
    end

    assign in_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_beat  = beat_reg;

endmodule

@@ hw/rtl/jkam_offset.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_offset
// Stage 2: source window match and glyph offsets for both fonts.
// ----------------------------------------------------------------------------
module jkam_offset import jkam_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  dec_beat_t  up_beat,
    output logic       dn_valid,
    input  logic       dn_ready,
    output base_beat_t dn_beat
);

    logic        valid_reg;
    base_beat_t  beat_reg;
    base_beat_t  beat_next;

    logic              hit;
    logic [15:0]       start;
    logic [SRC_W-1:0]  base;
    logic [15:0]       diff;

    always_comb
    begin
        hit   = 1'b1;
        start = SJ_A_LO;
        base  = SRC_BASE_A;
        priority if (up_beat.sj >= SJ_A_LO && up_beat.sj < SJ_A_HI)
        begin
            start = SJ_A_LO;
            base  = SRC_BASE_A;
        end
        else if (up_beat.sj >= SJ_B_LO && up_beat.sj < SJ_B_HI)
        begin
            start = SJ_B_LO;
            base  = SRC_BASE_B;
        end
        else if (up_beat.sj >= SJ_C_LO && up_beat.sj < SJ_C_HI)
        begin
            start = SJ_C_LO;
            base  = SRC_BASE_C;
        end
        else
        begin
            hit = 1'b0;
        end
        diff = up_beat.sj - start;

        beat_next.ok  = up_beat.ok && hit;
        // 32 bytes per glyph
        beat_next.src = base + {diff[13:0], 5'b0_0000};
        beat_next.dst = {up_beat.bank, up_beat.cell_hi, up_beat.cell_lo, 4'b0000};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_beat  = beat_reg;

endmodule

@@ hw/rtl/jkam_row_gen.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_row_gen
// Stage 3: expands one glyph into per-row beats from running offset registers.
// ----------------------------------------------------------------------------
module jkam_row_gen import jkam_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    output logic       up_ready,
    input  base_beat_t up_beat,
    jkam_row_if.source row_ch
);

    logic               valid_reg;
    logic               copy_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [SRC_W-1:0]   src_reg;
    logic [LEFT_W-1:0]  left_reg;
    logic [RIGHT_W-1:0] right_reg;
    logic               last_reg;

    logic               take;
    logic               step;
    logic [ROW_W-1:0]   row_next;

    assign take     = up_valid && up_ready;
    assign step     = valid_reg && row_ch.ready && !last_reg;
    assign row_next = row_reg + ROW_W'(1);
    // free once the final beat of the current glyph leaves
    assign up_ready = !valid_reg || (row_ch.ready && last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            copy_reg <= up_beat.ok;
            row_reg  <= '0;
            if (up_beat.ok)
            begin
                src_reg   <= up_beat.src;
                left_reg  <= up_beat.dst;
                right_reg <= {1'b0, up_beat.dst} + RIGHT_HALF_OFFSET;
                last_reg  <= (ROW_LAST == '0);
            end
            else
            begin
                src_reg   <= '0;
                left_reg  <= '0;
                right_reg <= '0;
                last_reg  <= 1'b1;
            end
        end
        else if (step)
        begin
            row_reg   <= row_next;
            src_reg   <= src_reg + SRC_W'(2);
            left_reg  <= left_reg + LEFT_W'(1);
            right_reg <= right_reg + RIGHT_W'(1);
            last_reg  <= (row_next == ROW_LAST);
        end
    end

    assign row_ch.valid             = valid_reg;
    assign row_ch.copy_valid        = copy_reg;
    assign row_ch.row_index         = row_reg;
    assign row_ch.source_offset     = src_reg;
    assign row_ch.dest_left_offset  = left_reg;
    assign row_ch.dest_right_offset = right_reg;
    assign row_ch.last_row          = last_reg;

endmodule

@@ hw/rtl/jkam_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jkam_checker
// Port-level checks on the row output of the address map unit.
// ----------------------------------------------------------------------------
module jkam_checker import jkam_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               valid,
    input logic               ready,
    input logic               copy_valid,
    input logic [ROW_W-1:0]   row_index,
    input logic [SRC_W-1:0]   source_offset,
    input logic [LEFT_W-1:0]  dest_left_offset,
    input logic [RIGHT_W-1:0] dest_right_offset,
    input logic               last_row
);

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(row_index) && $stable(source_offset)
            && $stable(last_row) && $stable(copy_valid))
        else $error("row beat changed while stalled");

    a_invalid_shape: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !copy_valid |-> last_row && row_index == '0 && source_offset == '0
            && dest_left_offset == '0 && dest_right_offset == '0)
        else $error("invalid result not all zero with last_row");

    a_right_half: assert property (@(posedge clk) disable iff (!rst_n)
        valid && copy_valid |-> dest_right_offset == {1'b0, dest_left_offset} + RIGHT_HALF_OFFSET)
        else $error("right half offset mismatch");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && copy_valid |-> last_row == (row_index == ROW_LAST))
        else $error("last_row not on final glyph row");

    // rows of one glyph follow without gaps
    a_next_row: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && !last_row |=> valid && copy_valid
            && row_index == $past(row_index) + ROW_W'(1)
            && source_offset == $past(source_offset) + SRC_W'(2))
        else $error("row sequence broken");

endmodule

bind jis_kanji_rom_address_map_unit jkam_checker u_jkam_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .valid             (row_ch.valid),
    .ready             (row_ch.ready),
    .copy_valid        (row_ch.copy_valid),
    .row_index         (row_ch.row_index),
    .source_offset     (row_ch.source_offset),
    .dest_left_offset  (row_ch.dest_left_offset),
    .dest_right_offset (row_ch.dest_right_offset),
    .last_row          (row_ch.last_row)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Sends JIS codes to the kanji ROM address map unit and checks every row beat
// against a predictor of the source font and split-ROM offsets.
// ----------------------------------------------------------------------------
module testbench;

    import jkam_pkg::*;

    localparam int unsigned RANDOM_CODES = 346;
    localparam int unsigned CALM_TAIL    = 40;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic               copy_valid;
        logic [ROW_W-1:0]   row_index;
        logic [SRC_W-1:0]   source_offset;
        logic [LEFT_W-1:0]  dest_left_offset;
        logic [RIGHT_W-1:0] dest_right_offset;
        logic               last_row;
    } glyph_row_t;

    class glyph_row_scoreboard;
        glyph_row_t  rows_due[$];
        int unsigned mismatches = 0;

        function int unsigned pending();
            return rows_due.size();
        endfunction

        task report(input string msg);
            mismatches++;
            $display("%0t ns: %s", $time, msg);
        endtask

        // Works out the row beats for one accepted code.
        function void note_code(input logic [CODE_W-1:0] code);
            logic [7:0]        jrow;
            logic [7:0]        jcell;
            logic [7:0]        lead;
            logic [7:0]        trail;
            logic [15:0]       sj;
            logic [7:0]        bank;
            logic [SRC_W-1:0]  src;
            logic [LEFT_W-1:0] dst;
            bit                mapped;
            glyph_row_t        beat;

            jrow   = code[15:8];
            jcell  = code[7:0];
            src    = '0;
            mapped = jrow >= 8'h21 && jrow <= 8'h7e && jcell >= 8'h21 && jcell <= 8'h7e;

            lead  = 8'(((jrow + 1) >> 1) + (jrow <= 8'h5e ? 8'h70 : 8'hb0));
            trail = jrow[0] ? 8'(jcell + (jcell >= 8'h60 ? 8'h20 : 8'h1f))
                            : 8'(jcell + 8'h7e);
            sj    = {lead, trail};

            if (sj >= SJ_A_LO && sj < SJ_A_HI)
            begin
                src = SRC_BASE_A + (SRC_W'(sj - SJ_A_LO) << 5);
            end
            else if (sj >= SJ_B_LO && sj < SJ_B_HI)
            begin
                src = SRC_BASE_B + (SRC_W'(sj - SJ_B_LO) << 5);
            end
            else if (sj >= SJ_C_LO && sj < SJ_C_HI)
            begin
                src = SRC_BASE_C + (SRC_W'(sj - SJ_C_LO) << 5);
            end
            else
            begin
                mapped = 0;
            end

            // bank index is code[14:11] over code[6:5]; top two bits set = hole
            bank = BANK_TABLE[{code[14:11], code[6:5]}];
            if (bank[7:6] != 2'b00)
            begin
                mapped = 0;
            end
            dst = (LEFT_W'(bank) << 12) + (LEFT_W'(code[10:8]) << 9)
                + (LEFT_W'(code[4:0]) << 4);

            if (!mapped)
            begin
                beat          = '0;
                beat.last_row = 1'b1;
                rows_due.push_back(beat);
                return;
            end
            for (int r = 0; r < ROWS_PER_GLYPH; r++)
            begin
                beat.copy_valid        = 1'b1;
                beat.row_index         = ROW_W'(r);
                beat.source_offset     = src + SRC_W'(2 * r);
                beat.dest_left_offset  = dst + LEFT_W'(r);
                beat.dest_right_offset = RIGHT_W'(dst) + RIGHT_W'(r) + RIGHT_HALF_OFFSET;
                beat.last_row          = (r == ROWS_PER_GLYPH - 1);
                rows_due.push_back(beat);
            end
        endfunction

        task check_row(input glyph_row_t got);
            glyph_row_t want;

            if (rows_due.size() == 0)
            begin
                report($sformatf("row beat with nothing due: %p", got));
                return;
            end
            want = rows_due.pop_front();
            if (got.copy_valid !== want.copy_valid)
                report($sformatf("copy_valid %0b, want %0b", got.copy_valid, want.copy_valid));
            if (got.row_index !== want.row_index)
                report($sformatf("row_index %0d, want %0d", got.row_index, want.row_index));
            if (got.source_offset !== want.source_offset)
                report($sformatf("source_offset %h, want %h",
                                 got.source_offset, want.source_offset));
            if (got.dest_left_offset !== want.dest_left_offset)
                report($sformatf("dest_left_offset %h, want %h",
                                 got.dest_left_offset, want.dest_left_offset));
            if (got.dest_right_offset !== want.dest_right_offset)
                report($sformatf("dest_right_offset %h, want %h",
                                 got.dest_right_offset, want.dest_right_offset));
            if (got.last_row !== want.last_row)
                report($sformatf("last_row %0b, want %0b", got.last_row, want.last_row));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    jkam_code_if code_ch();
    jkam_row_if  row_ch();

    glyph_row_scoreboard book = new();
    bit          calm = 0;
    int unsigned quiet_cycles = 0;

    jis_kanji_rom_address_map_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .code_ch (code_ch),
        .row_ch  (row_ch)
    );

    always #6 clk = ~clk;

    // Mostly row/cell inside the kanji square, with some edge values and raw noise.
    function automatic logic [CODE_W-1:0] pick_code();
        logic [7:0] edges [4] = '{8'h20, 8'h21, 8'h7e, 8'h7f};

        case ($urandom_range(0, 9))
            0:       return {edges[$urandom_range(0, 3)], 8'($urandom_range(8'h21, 8'h7e))};
            1:       return {8'($urandom_range(8'h21, 8'h7e)), edges[$urandom_range(0, 3)]};
            2, 3, 4: return 16'($urandom);
            default: return {8'($urandom_range(8'h21, 8'h7e)), 8'($urandom_range(8'h21, 8'h7e))};
        endcase
    endfunction

    task automatic send_code(input logic [CODE_W-1:0] code);
        code_ch.valid    <= 1'b1;
        code_ch.jis_code <= code;
        do @(posedge clk); while (!code_ch.ready);
        book.note_code(code);
    endtask

    // Sink side: ready drops in bursts, except in the calm tail.
    initial
    begin
        row_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                row_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            row_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : row_monitor
        glyph_row_t seen;

        if (rst_n && row_ch.valid && row_ch.ready)
        begin
            seen.copy_valid        = row_ch.copy_valid;
            seen.row_index         = row_ch.row_index;
            seen.source_offset     = row_ch.source_offset;
            seen.dest_left_offset  = row_ch.dest_left_offset;
            seen.dest_right_offset = row_ch.dest_right_offset;
            seen.last_row          = row_ch.last_row;
            book.check_row(seen);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((code_ch.valid && code_ch.ready) || (row_ch.valid && row_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [CODE_W-1:0] codes[$];
        int unsigned       idle_odds;

        // corners, window edges, odd/even row trail rule, lead switch, bank holes
        codes = '{16'h0000, 16'hffff, 16'h2121, 16'h7e7e, 16'h2020, 16'h217f,
                  16'h7f21, 16'h8080, 16'ha1a1, 16'h2221, 16'h235f, 16'h2360,
                  16'h5e21, 16'h5e7e, 16'h5f21, 16'h2921, 16'h2f6f, 16'h2f70,
                  16'h2821, 16'h7021, 16'h747e, 16'h7521, 16'h3021, 16'h4f4f};
        repeat (RANDOM_CODES) codes.push_back(pick_code());

        rst_n            <= 1'b0;
        code_ch.valid    <= 1'b0;
        code_ch.jis_code <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idle_odds = 0;
        foreach (codes[i])
        begin
            if (i % 50 == 0)
            begin
                idle_odds = $urandom_range(0, 4);
            end
            if (i + CALM_TAIL >= codes.size())
            begin
                calm = 1;
            end
            if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                code_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            send_code(codes[i]);
        end
        code_ch.valid <= 1'b0;

        while (book.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.mismatches == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/jkam_pkg.sv
hw/rtl/jkam_code_if.sv
hw/rtl/jkam_row_if.sv
hw/rtl/jkam_decode.sv
hw/rtl/jkam_offset.sv
hw/rtl/jkam_row_gen.sv
hw/rtl/jis_kanji_rom_address_map_unit.sv
hw/rtl/jkam_checker.sv
tb/sv/testbench.sv
